/* rtl/core/rrwl_pkg.sv */
`default_nettype none
package rrwl_pkg;

	localparam int REQUESTERS_DEF = 16;
	localparam int MAX_DEPTH_DEF  = 255;

	localparam int ID_W    = 4;
	localparam int DEPTH_W = 8;
	localparam int TOTAL_W = 12;

	localparam logic [TOTAL_W-1:0] TOTAL_CAP = 12'd4095;

	typedef enum logic [2:0] {
		REQ_TRY_READ  = 3'd0,
		REQ_REL_READ  = 3'd1,
		REQ_TRY_WRITE = 3'd2,
		REQ_REL_WRITE = 3'd3,
		REQ_QUERY     = 3'd4
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BUSY     = 2'd1,
		ST_MISUSE   = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

endpackage
`default_nettype wire

/* rtl/core/rrwl_depth_mem.sv */
`default_nettype none
module rrwl_depth_mem #(
	parameter int DEPTH = rrwl_pkg::REQUESTERS_DEF,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rd_en,
	input  wire logic [IDX_W-1:0]             rd_addr,
	output logic      [rrwl_pkg::DEPTH_W-1:0] rd_data,
	input  wire logic                         wr_en,
	input  wire logic [IDX_W-1:0]             wr_addr,
	input  wire logic [rrwl_pkg::DEPTH_W-1:0] wr_data
);

	logic [rrwl_pkg::DEPTH_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]             vld_q;
	logic [rrwl_pkg::DEPTH_W-1:0] rd_data_q;
	logic                         rd_vld_q;

	// entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule
`default_nettype wire

/* rtl/core/recursive_rw_lock_arbiter_unit.sv */
// a request transfer registers the request and starts the depth-memory read;
//   the exec state then decides and registers the result, waiting while an unaccepted
//   result still occupies the result register; a new request is taken only after
//   the current one has executed, since it reads and then writes back the depth memory
// a waiting result does not block the next request transfer
// reset: asynchronous, clears lock state, fsm, result valid and the memory valid bits;
//   no clearing pass, unwritten depth entries read as zero
`default_nettype none
module recursive_rw_lock_arbiter_unit #(
	parameter int REQUESTERS = rrwl_pkg::REQUESTERS_DEF,
	parameter int MAX_DEPTH  = rrwl_pkg::MAX_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// request channel
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire logic [2:0]                   req_type,
	input  wire logic [rrwl_pkg::ID_W-1:0]    requester_id,
	// result channel
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output logic                              granted,
	output logic      [1:0]                   status_code,
	output logic                              holds_read,
	output logic                              holds_write,
	output logic      [rrwl_pkg::DEPTH_W-1:0] own_read_depth,
	output logic                              others_reading
);

	localparam int IDX_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
	localparam int EXT_W = 9;
	localparam logic [rrwl_pkg::DEPTH_W-1:0] DEPTH_CAP =
		(MAX_DEPTH < 255) ? rrwl_pkg::DEPTH_W'(MAX_DEPTH) : 8'd255;

	// one-hot sequencer: idle takes a request and starts the table read,
	// exec sees the read data, decides and writes back
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} fsm_t;

	fsm_t state_q;

	// request held for the execute cycle
	logic [2:0]                type_q;
	logic [rrwl_pkg::ID_W-1:0] id_q;
	logic                      id_ok_q;

	// lock state outside the table
	logic [rrwl_pkg::TOTAL_W-1:0] total_q;
	logic                         wr_active_q;
	logic [rrwl_pkg::ID_W-1:0]    wr_owner_q;
	logic [rrwl_pkg::DEPTH_W-1:0] wr_depth_q;

	// result register
	logic                         rsp_valid_q;
	logic                         granted_q;
	logic [1:0]                   status_q;
	logic                         holds_read_q;
	logic                         holds_write_q;
	logic [rrwl_pkg::DEPTH_W-1:0] own_q;
	logic                         others_q;

	logic                         accept;
	logic                         fire;
	logic [EXT_W-1:0]             id_ext;
	logic                         id_ok;
	logic [IDX_W-1:0]             rd_idx;
	logic [IDX_W-1:0]             wr_idx;
	logic [EXT_W-1:0]             id_q_ext;
	logic [rrwl_pkg::DEPTH_W-1:0] tbl_rd;

	// decision outputs
	logic [rrwl_pkg::DEPTH_W-1:0] own;
	logic                         is_writer;
	logic                         n_granted;
	rrwl_pkg::status_t            n_status;
	logic                         tbl_we;
	logic [rrwl_pkg::DEPTH_W-1:0] n_own;
	logic [rrwl_pkg::TOTAL_W-1:0] n_total;
	logic                         n_wr_active;
	logic [rrwl_pkg::ID_W-1:0]    n_wr_owner;
	logic [rrwl_pkg::DEPTH_W-1:0] n_wr_depth;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	// execute only when the result register is free or being emptied
	assign fire      = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);

	assign id_ext   = {{(EXT_W-rrwl_pkg::ID_W){1'b0}}, requester_id};
	assign id_ok    = id_ext < EXT_W'(REQUESTERS);
	assign rd_idx   = id_ext[IDX_W-1:0];
	assign id_q_ext = {{(EXT_W-rrwl_pkg::ID_W){1'b0}}, id_q};
	assign wr_idx   = id_q_ext[IDX_W-1:0];

	rrwl_depth_mem #(
		.DEPTH(REQUESTERS)
	) u_depth_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(rd_idx),
		.rd_data(tbl_rd),
		.wr_en  (fire && tbl_we),
		.wr_addr(wr_idx),
		.wr_data(n_own)
	);

	// read and write-back never fall in the same cycle, so no forwarding is needed

	always_comb begin
		own         = id_ok_q ? tbl_rd : '0;
		is_writer   = id_ok_q && wr_active_q && (wr_owner_q == id_q);
		n_granted   = 1'b0;
		n_status    = rrwl_pkg::ST_OK;
		tbl_we      = 1'b0;
		n_own       = own;
		n_total     = total_q;
		n_wr_active = wr_active_q;
		n_wr_owner  = wr_owner_q;
		n_wr_depth  = wr_depth_q;
		if (!id_ok_q) begin
			n_status = rrwl_pkg::ST_MISUSE;
		end else begin
			case (type_q)
				rrwl_pkg::REQ_TRY_READ: begin
					if (wr_active_q && !is_writer) begin
						n_status = rrwl_pkg::ST_BUSY;
					end else if (own >= DEPTH_CAP || total_q >= rrwl_pkg::TOTAL_CAP) begin
						n_status = rrwl_pkg::ST_OVERFLOW;
					end else begin
						n_own     = own + 8'd1;
						n_total   = total_q + 12'd1;
						tbl_we    = 1'b1;
						n_granted = 1'b1;
					end
				end
				rrwl_pkg::REQ_REL_READ: begin
					if (own == '0) begin
						n_status = rrwl_pkg::ST_MISUSE;
					end else begin
						n_own     = own - 8'd1;
						n_total   = total_q - 12'd1;
						tbl_we    = 1'b1;
						n_granted = 1'b1;
					end
				end
				rrwl_pkg::REQ_TRY_WRITE: begin
					// upgrade from a held read is misuse
					if (own != '0) begin
						n_status = rrwl_pkg::ST_MISUSE;
					end else if (is_writer) begin
						if (wr_depth_q >= DEPTH_CAP) begin
							n_status = rrwl_pkg::ST_OVERFLOW;
						end else begin
							n_wr_depth = wr_depth_q + 8'd1;
							n_granted  = 1'b1;
						end
					end else if (!wr_active_q && total_q == '0) begin
						n_wr_active = 1'b1;
						n_wr_owner  = id_q;
						n_wr_depth  = 8'd1;
						n_granted   = 1'b1;
					end else begin
						n_status = rrwl_pkg::ST_BUSY;
					end
				end
				rrwl_pkg::REQ_REL_WRITE: begin
					if (!is_writer) begin
						n_status = rrwl_pkg::ST_MISUSE;
					end else begin
						if (wr_depth_q <= 8'd1) begin
							n_wr_active = 1'b0;
							n_wr_owner  = '0;
							n_wr_depth  = '0;
						end else begin
							n_wr_depth = wr_depth_q - 8'd1;
						end
						n_granted = 1'b1;
					end
				end
				rrwl_pkg::REQ_QUERY: begin
					n_status = rrwl_pkg::ST_OK;
				end
				default: begin
					n_status = rrwl_pkg::ST_MISUSE;
				end
			endcase
		end
	end

	// sequencer, lock registers and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			wr_active_q <= 1'b0;
			wr_owner_q  <= '0;
			wr_depth_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fire) begin
				total_q     <= n_total;
				wr_active_q <= n_wr_active;
				wr_owner_q  <= n_wr_owner;
				wr_depth_q  <= n_wr_depth;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request capture and result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q  <= req_type;
			id_q    <= requester_id;
			id_ok_q <= id_ok;
		end
		if (fire) begin
			granted_q     <= n_granted;
			status_q      <= n_status;
			holds_read_q  <= (n_own != '0);
			holds_write_q <= id_ok_q && n_wr_active && (n_wr_owner == id_q);
			own_q         <= n_own;
			others_q      <= (n_total != {{(rrwl_pkg::TOTAL_W-rrwl_pkg::DEPTH_W){1'b0}}, n_own});
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign granted        = granted_q;
	assign status_code    = status_q;
	assign holds_read     = holds_read_q;
	assign holds_write    = holds_write_q;
	assign own_read_depth = own_q;
	assign others_reading = others_q;

	// an active writer always has a nonzero depth
	a_writer_depth: assert property (@(posedge clk) disable iff (!arst_n)
		wr_active_q |-> (wr_depth_q != '0))
		else $error("writer active with zero depth");

	// no writer leaves owner and depth cleared
	a_writer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_active_q |-> (wr_depth_q == '0 && wr_owner_q == '0))
		else $error("writer fields not cleared");

	// a granted result always carries ok status
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && granted_q |-> (status_q == rrwl_pkg::ST_OK))
		else $error("grant with error status");

	// exec is entered only from a request transfer
	a_exec_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EXEC) |-> $past(accept))
		else $error("exec without request transfer");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;
	import rrwl_pkg::*;

	// request codes the block must reject as misuse
	localparam logic [2:0] REQ_RSVD_A = 3'd5;
	localparam logic [2:0] REQ_RSVD_B = 3'd6;
	localparam logic [2:0] REQ_RSVD_C = 3'd7;

	// nesting cap for a single reader or the writer
	localparam int DEPTH_CAP   = (MAX_DEPTH_DEF < 255) ? MAX_DEPTH_DEF : 255;
	localparam int RAND_ITEMS  = 700;
	localparam int STALL_LIMIT = 1000;

	typedef struct {
		logic           granted;
		status_t        status;
		logic           rd_held;
		logic           wr_held;
		logic [7:0]     depth;
		logic           others;
	} lock_result_t;

	typedef struct {
		logic [2:0]     kind;
		logic [3:0]     who;
		bit             fixed;
		lock_result_t   want;
	} lock_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	logic [2:0] req_type;
	logic [ID_W-1:0] requester_id;
	logic rsp_valid;
	logic rsp_ready;
	logic granted;
	logic [1:0] status_code;
	logic holds_read;
	logic holds_write;
	logic [DEPTH_W-1:0] own_read_depth;
	logic others_reading;

	// lock state as the checker sees it, advanced on every request transfer
	logic [DEPTH_W-1:0] lock_rd_depth [REQUESTERS_DEF];
	logic [TOTAL_W-1:0] lock_rd_total;
	logic               lock_wr_active;
	logic [ID_W-1:0]    lock_wr_owner;
	logic [DEPTH_W-1:0] lock_wr_depth;

	lock_result_t lock_expect_q [$];
	lock_row_t    lock_rows [$];

	// hand-typed expectation for the request currently on the bus
	bit           pin_fixed;
	lock_result_t pin_want;

	// no idling on either side while set
	bit burst;
	int fails;
	int stall_cycles;

	recursive_rw_lock_arbiter_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req_type       (req_type),
		.requester_id   (requester_id),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.granted        (granted),
		.status_code    (status_code),
		.holds_read     (holds_read),
		.holds_write    (holds_write),
		.own_read_depth (own_read_depth),
		.others_reading (others_reading)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one request against the lock state; updates the state and returns the answer
	function automatic lock_result_t lock_predict(input logic [2:0] kind,
			input logic [ID_W-1:0] who);
		lock_result_t r;
		logic [DEPTH_W-1:0] own;
		logic is_wr;
		r.granted = 1'b0;
		r.status = ST_OK;
		own = lock_rd_depth[who];
		is_wr = lock_wr_active && (lock_wr_owner == who);
		case (kind)
			REQ_TRY_READ: begin
				if (lock_wr_active && !is_wr) begin
					r.status = ST_BUSY;
				end else if (own >= DEPTH_CAP || lock_rd_total >= TOTAL_CAP) begin
					r.status = ST_OVERFLOW;
				end else begin
					lock_rd_depth[who] = own + 1'b1;
					lock_rd_total = lock_rd_total + 1'b1;
					r.granted = 1'b1;
				end
			end
			REQ_REL_READ: begin
				if (own == 0) begin
					r.status = ST_MISUSE;
				end else begin
					lock_rd_depth[who] = own - 1'b1;
					lock_rd_total = lock_rd_total - 1'b1;
					r.granted = 1'b1;
				end
			end
			REQ_TRY_WRITE: begin
				// a reader may not upgrade to writer
				if (own != 0) begin
					r.status = ST_MISUSE;
				end else if (is_wr) begin
					if (lock_wr_depth >= DEPTH_CAP) begin
						r.status = ST_OVERFLOW;
					end else begin
						lock_wr_depth = lock_wr_depth + 1'b1;
						r.granted = 1'b1;
					end
				end else if (!lock_wr_active && lock_rd_total == 0) begin
					lock_wr_active = 1'b1;
					lock_wr_owner = who;
					lock_wr_depth = 8'd1;
					r.granted = 1'b1;
				end else begin
					r.status = ST_BUSY;
				end
			end
			REQ_REL_WRITE: begin
				if (!is_wr) begin
					r.status = ST_MISUSE;
				end else begin
					if (lock_wr_depth <= 1) begin
						lock_wr_active = 1'b0;
						lock_wr_owner = '0;
						lock_wr_depth = '0;
					end else begin
						lock_wr_depth = lock_wr_depth - 1'b1;
					end
					r.granted = 1'b1;
				end
			end
			REQ_QUERY: begin
			end
			default: begin
				r.status = ST_MISUSE;
			end
		endcase
		own = lock_rd_depth[who];
		r.rd_held = (own != 0);
		r.wr_held = lock_wr_active && (lock_wr_owner == who);
		r.depth = own;
		r.others = (lock_rd_total != {4'd0, own});
		return r;
	endfunction

	task automatic report_field(input string what, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, act_v);
		end
	endtask

	// scoreboard: predict on request transfer, compare on result transfer
	always @(posedge clk) begin
		lock_result_t want;
		lock_result_t calc;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (lock_expect_q.size() == 0) begin
					fails++;
					$display("%0t: result transfer with nothing expected, expected none actual %0d/%0d",
						$time, granted, status_code);
				end else begin
					want = lock_expect_q.pop_front();
					report_field("granted", want.granted, granted);
					report_field("status_code", want.status, status_code);
					report_field("holds_read", want.rd_held, holds_read);
					report_field("holds_write", want.wr_held, holds_write);
					report_field("own_read_depth", want.depth, own_read_depth);
					report_field("others_reading", want.others, others_reading);
				end
			end
			if (req_valid && req_ready) begin
				calc = lock_predict(req_type, requester_id);
				// typed-in rows replace the prediction, the state still advances
				lock_expect_q.push_back(pin_fixed ? pin_want : calc);
			end
		end
	end

	// watchdog: cycles since the last transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	// result side: random back-pressure before each transfer, none while burst is set
	initial begin
		int hold;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			hold = burst ? 0 : $urandom_range(0, 3);
			if (hold != 0) begin
				rsp_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
		end
	end

	// present one request from a falling edge, return at the falling edge after its transfer
	task automatic send_req(input logic [2:0] kind, input logic [ID_W-1:0] who);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		requester_id <= who;
		do @(posedge clk); while (!(req_valid && req_ready));
		@(negedge clk);
	endtask

	// hold requests back until every result has come out
	task automatic settle;
		req_valid <= 1'b0;
		while (lock_expect_q.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic add_row(input logic [2:0] kind, input logic [ID_W-1:0] who,
			input bit fixed, input logic g, input status_t st, input logic hr,
			input logic hw, input logic [7:0] d, input logic o);
		lock_row_t row;
		row.kind = kind;
		row.who = who;
		row.fixed = fixed;
		row.want.granted = g;
		row.want.status = st;
		row.want.rd_held = hr;
		row.want.wr_held = hw;
		row.want.depth = d;
		row.want.others = o;
		lock_rows.push_back(row);
	endtask

	initial begin
		int sent;
		int n;
		int k;
		logic [ID_W-1:0] who;
		logic [ID_W-1:0] peer;
		logic [ID_W-1:0] owner;
		logic [2:0] kind;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = REQ_QUERY;
		requester_id = '0;
		pin_fixed = 1'b0;
		burst = 1'b0;
		fails = 0;
		stall_cycles = 0;
		lock_rd_total = '0;
		lock_wr_active = 1'b0;
		lock_wr_owner = '0;
		lock_wr_depth = '0;
		foreach (lock_rd_depth[i]) lock_rd_depth[i] = '0;

		// directed rows; typed answers only where obvious
		add_row(REQ_QUERY,     4'd0,  1, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_RSVD_A,    4'd3,  1, 0, ST_MISUSE, 0, 0, 8'd0, 0);
		add_row(REQ_RSVD_B,    4'd15, 1, 0, ST_MISUSE, 0, 0, 8'd0, 0);
		add_row(REQ_RSVD_C,    4'd0,  1, 0, ST_MISUSE, 0, 0, 8'd0, 0);
		// releases of a lock that is not held, then two first reads
		add_row(REQ_REL_READ,  4'd15, 1, 0, ST_MISUSE, 0, 0, 8'd0, 0);
		add_row(REQ_REL_WRITE, 4'd9,  1, 0, ST_MISUSE, 0, 0, 8'd0, 0);
		add_row(REQ_TRY_READ,  4'd0,  1, 1, ST_OK,     1, 0, 8'd1, 0);
		add_row(REQ_TRY_READ,  4'd15, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		// reader asking for write, then a write blocked by readers, then both readers release
		add_row(REQ_TRY_WRITE, 4'd0,  0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_TRY_WRITE, 4'd5,  0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_REL_READ,  4'd0,  0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_REL_READ,  4'd15, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		// nested write, a read blocked by it, the writer reading and asking to write again, then release
		add_row(REQ_TRY_WRITE, 4'd10, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_TRY_WRITE, 4'd10, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_TRY_READ,  4'd3,  0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_TRY_READ,  4'd10, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_TRY_WRITE, 4'd10, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_REL_WRITE, 4'd3,  0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_REL_READ,  4'd10, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_REL_WRITE, 4'd10, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_REL_WRITE, 4'd10, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_TRY_WRITE, 4'd15, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_QUERY,     4'd15, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_REL_WRITE, 4'd15, 0, 0, ST_OK,     0, 0, 8'd0, 0);
		add_row(REQ_QUERY,     4'd6,  0, 0, ST_OK,     0, 0, 8'd0, 0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (lock_rows[i]) begin
			pin_fixed = lock_rows[i].fixed;
			pin_want = lock_rows[i].want;
			send_req(lock_rows[i].kind, lock_rows[i].who);
		end
		pin_fixed = 1'b0;
		// sender pauses until the block has drained
		settle();

		// depth limits: one reader to its cap and past it, then one writer
		who = 4'($urandom_range(0, 15));
		peer = who + 4'd1;
		repeat (DEPTH_CAP + 1) send_req(REQ_TRY_READ, who);
		send_req(REQ_TRY_WRITE, peer);
		repeat (DEPTH_CAP) send_req(REQ_REL_READ, who);
		send_req(REQ_REL_READ, who);
		who = 4'($urandom_range(0, 15));
		repeat (DEPTH_CAP + 1) send_req(REQ_TRY_WRITE, who);
		send_req(REQ_TRY_READ, who + 4'd7);
		repeat (DEPTH_CAP) send_req(REQ_REL_WRITE, who);
		settle();

		// random episodes, mostly well-formed lock sessions with noise around them
		sent = 0;
		while (sent < RAND_ITEMS) begin
			burst = ($urandom_range(0, 4) == 0);
			who = 4'($urandom_range(0, 15));
			k = $urandom_range(0, 9);
			if (k <= 3) begin
				// nested read session, other requesters interleaved
				n = $urandom_range(1, 6);
				repeat (n) begin
					send_req(REQ_TRY_READ, who);
					sent++;
					if ($urandom_range(0, 3) == 0) begin
						send_req($urandom_range(0, 1) ? REQ_TRY_READ : REQ_TRY_WRITE,
							4'($urandom_range(0, 15)));
						sent++;
					end
				end
				repeat (n) begin
					send_req(REQ_REL_READ, who);
					sent++;
				end
			end else if (k <= 6) begin
				// nested write session, writer may also read
				n = $urandom_range(1, 5);
				repeat (n) begin
					send_req(REQ_TRY_WRITE, who);
					sent++;
				end
				if ($urandom_range(0, 1)) begin
					send_req(REQ_TRY_READ, who);
					send_req(REQ_TRY_WRITE, who);
					send_req(REQ_REL_READ, who);
					sent += 3;
				end
				send_req($urandom_range(0, 1) ? REQ_TRY_READ : REQ_REL_WRITE,
					4'($urandom_range(0, 15)));
				sent++;
				repeat (n) begin
					send_req(REQ_REL_WRITE, who);
					sent++;
				end
			end else if (k <= 8) begin
				// noise, mostly legal codes
				repeat (8) begin
					n = $urandom_range(0, 15);
					kind = (n < 13) ? 3'(n % 5) : 3'(REQ_RSVD_A + (n - 13));
					send_req(kind, 4'($urandom_range(0, 15)));
					sent++;
				end
			end else begin
				// release whatever noise left held
				for (int i = 0; i < REQUESTERS_DEF; i++) begin
					n = lock_rd_depth[i];
					repeat (n) begin
						send_req(REQ_REL_READ, 4'(i));
						sent++;
					end
				end
				if (lock_wr_active) begin
					owner = lock_wr_owner;
					n = lock_wr_depth;
					repeat (n) begin
						send_req(REQ_REL_WRITE, owner);
						sent++;
					end
				end
			end
		end
		burst = 1'b0;

		req_valid <= 1'b0;
		while (lock_expect_q.size() != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0 && lock_expect_q.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
